/* sv/chs_pkg.sv */
// compass heading package: widths, angle constants and the degree-scaled arctangent table
// no dependencies; used by every module of the block

package chs_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_BITS    = 6;
	localparam int TABLE_LEN    = 24;
	localparam int NUM_STEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int CNT_W        = $clog2(NUM_STEPS);
	localparam int TBL_IDX_W    = $clog2(TABLE_LEN);

	localparam int IN_W   = 16;
	localparam int OUT_W  = 15;
	// vector grows by the cordic gain on top of the 17-bit negated sample
	localparam int XY_W   = 20;
	localparam int ANGLE_BITS = 24;
	// angle spans about -100 to 280 degrees before the fold
	localparam int Z_W    = 34;
	localparam int ATAN_W = 30;
	localparam int SHIFT  = ANGLE_BITS - FRAC_BITS;

	localparam int HALF_TURN_DEG = 180;
	localparam int FULL_TURN_DEG = 360;

	localparam logic signed [Z_W-1:0] HALF_Z = Z_W'(HALF_TURN_DEG) <<< ANGLE_BITS;
	localparam logic signed [Z_W-1:0] FULL_Z = Z_W'(FULL_TURN_DEG) <<< ANGLE_BITS;
	localparam logic signed [Z_W-1:0] ROUND_Z = Z_W'(1) <<< (SHIFT - 1);
	localparam logic signed [Z_W-1:0] FULL_Q = Z_W'(FULL_TURN_DEG) <<< FRAC_BITS;

	// atan(2^-i) in degrees times 2^24, rounded to nearest
	localparam logic [ATAN_W-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
		30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
		30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
		30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
		30'd234684,    30'd117342,    30'd58671,     30'd29335,
		30'd14668,     30'd7334,      30'd3667,      30'd1833,
		30'd917,       30'd458,       30'd229,       30'd115
	};

endpackage

/* sv/compass_heading_atan2.sv */
// compass heading top level: sequencer, vector and angle registers, fold and rounding, output register
// depends on chs_pkg and chs_step_unit

// Takes one signed X/Y magnetometer sample pair and returns atan2(y,x) as a heading in
// degrees times 64, 0 up to 359.984, with a full circle wrapping to 0 and a zero vector
// giving 0. An item passes from its transfer through the step, fold and round states to the
// loaded result: one shared micro-rotation unit runs once per cycle over the cordic steps,
// then the fold state adds a full turn to a negative angle and the round state rounds.
// mag_stall is high from the transfer until the result is loaded, so a new sample is taken only
// back in idle; a finished result sits in the output register while the next sample is taken, and
// rounding waits only if that register is still held by heading_stall.
module compass_heading_atan2 (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              mag_valid,
	output logic                              mag_stall,
	input  logic signed [chs_pkg::IN_W-1:0]   mag_x,
	input  logic signed [chs_pkg::IN_W-1:0]   mag_y,
	output logic                              heading_valid,
	input  logic                              heading_stall,
	output logic        [chs_pkg::OUT_W-1:0]  heading_deg
);
	import chs_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ITER  = 2'd1;
	localparam logic [1:0] ST_FOLD  = 2'd2;
	localparam logic [1:0] ST_ROUND = 2'd3;

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	logic                   zero_q;
	logic                   heading_valid_q;
	logic [OUT_W-1:0]       heading_deg_q;

	logic signed [XY_W-1:0] x_next;
	logic signed [XY_W-1:0] y_next;
	logic signed [Z_W-1:0]  z_next;
	logic signed [XY_W-1:0] x_in;
	logic signed [XY_W-1:0] y_in;
	logic signed [Z_W-1:0]  z_fold;
	logic signed [Z_W-1:0]  z_rnd;
	logic signed [Z_W-1:0]  q_full;
	logic signed [Z_W-1:0]  q_wrap;
	logic                   mag_xfer;
	logic                   out_xfer;
	logic                   out_load;

	assign mag_stall = (state_q != ST_IDLE);
	assign mag_xfer  = mag_valid && !mag_stall;
	assign out_xfer  = heading_valid_q && !heading_stall;
	assign out_load  = (state_q == ST_ROUND) && (!heading_valid_q || !heading_stall);

	assign heading_valid = heading_valid_q;
	assign heading_deg   = heading_deg_q;

	assign x_in = XY_W'(mag_x);
	assign y_in = XY_W'(mag_y);

	chs_step_unit u_step (
		.x      (x_q),
		.y      (y_q),
		.z      (z_q),
		.idx    (cnt_q),
		.x_next (x_next),
		.y_next (y_next),
		.z_next (z_next)
	);

	always_comb begin
		z_fold = z_q;
		if (z_q[Z_W-1]) begin
			z_fold = z_q + FULL_Z;
		end
		if (z_fold[Z_W-1]) begin
			z_fold = '0;
		end
	end

	// round half up, then wrap a full circle back to zero
	always_comb begin
		z_rnd  = z_q + ROUND_Z;
		q_full = z_rnd >>> SHIFT;
		q_wrap = (q_full >= FULL_Q) ? (q_full - FULL_Q) : q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (mag_xfer) begin
						state_q <= ST_ITER;
						cnt_q   <= '0;
					end
				end
				ST_ITER: begin
					if (cnt_q == CNT_W'(NUM_STEPS - 1)) begin
						state_q <= ST_FOLD;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_FOLD: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mag_xfer) begin
			zero_q <= (mag_x == '0) && (mag_y == '0);
			// left half plane: negate the vector and start from a half turn
			if (mag_x[IN_W-1]) begin
				x_q <= -x_in;
				y_q <= -y_in;
				z_q <= HALF_Z;
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= '0;
			end
		end else if (state_q == ST_ITER) begin
			x_q <= x_next;
			y_q <= y_next;
			z_q <= z_next;
		end else if (state_q == ST_FOLD) begin
			z_q <= z_fold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_valid_q <= 1'b0;
		end else if (out_load) begin
			heading_valid_q <= 1'b1;
		end else if (out_xfer) begin
			heading_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			heading_deg_q <= zero_q ? '0 : q_wrap[OUT_W-1:0];
		end
	end

`ifndef SYNTHESIS
	a_start_iter: assert property (@(posedge clk) disable iff (!arst_n)
		mag_xfer |=> (state_q == ST_ITER) && (cnt_q == '0))
		else $error("accepted sample did not start the step sequence");

	a_round_after_fold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |->
			($past(state_q) == ST_FOLD) || ($past(state_q) == ST_ROUND))
		else $error("rounding entered without folding");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(heading_valid_q && heading_stall) |=> $stable(heading_deg_q))
		else $error("held result overwritten");

	a_iter_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER) |-> (cnt_q <= CNT_W'(NUM_STEPS - 1)))
		else $error("step counter out of range");
`endif

endmodule

/* sv/chs_step_unit.sv */
// one cordic vectoring micro-rotation: shift, add/subtract on x and y, table add on the angle
// depends on chs_pkg

module chs_step_unit (
	input  logic signed [chs_pkg::XY_W-1:0]  x,
	input  logic signed [chs_pkg::XY_W-1:0]  y,
	input  logic signed [chs_pkg::Z_W-1:0]   z,
	input  logic        [chs_pkg::CNT_W-1:0] idx,
	output logic signed [chs_pkg::XY_W-1:0]  x_next,
	output logic signed [chs_pkg::XY_W-1:0]  y_next,
	output logic signed [chs_pkg::Z_W-1:0]   z_next
);
	import chs_pkg::*;

	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic signed [Z_W-1:0]  atan_z;

	// arithmetic shift rounds toward minus infinity
	assign dx = y >>> idx;
	assign dy = x >>> idx;
	assign atan_z = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_TABLE[TBL_IDX_W'(idx)]});

	always_comb begin
		if (!y[XY_W-1]) begin
			x_next = x + dx;
			y_next = y - dy;
			z_next = z + atan_z;
		end else begin
			x_next = x - dx;
			y_next = y + dy;
			z_next = z - atan_z;
		end
	end

endmodule
